// ===== rtl/core/kpd_pkg.sv =====
`default_nettype none
package kpd_pkg;

    localparam int unsigned TICK_W     = 32;
    localparam int unsigned LINES_W    = 16;
    localparam int unsigned KEY_W      = 5;
    localparam int unsigned DEB_W      = 16;
    localparam int unsigned KEY_COUNT  = 16;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [KEY_W-1:0] NO_KEY         = 5'd0;

    typedef logic [TICK_W-1:0]  t_tick;
    typedef logic [LINES_W-1:0] t_lines;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [DEB_W-1:0]   t_deb;

    typedef struct packed {
        logic  adv;
        t_tick now_tick;
        t_key  raw_key;
    } t_step;

    typedef struct packed {
        t_key confirmed_key;
        logic held_flag;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/kpd_if.sv =====
`default_nettype none
interface kpd_in_if;
    import kpd_pkg::*;
    logic   valid;
    logic   ready;
    t_tick  now_tick;
    t_lines key_lines;
    modport source (output valid, output now_tick, output key_lines, input ready);
    modport sink   (input valid, input now_tick, input key_lines, output ready);
endinterface

interface kpd_out_if;
    import kpd_pkg::*;
    logic valid;
    logic ready;
    t_key confirmed_key;
    logic held_flag;
    modport source (output valid, output confirmed_key, output held_flag, input ready);
    modport sink   (input valid, input confirmed_key, input held_flag, output ready);
endinterface

interface kpd_cfg_if;
    import kpd_pkg::*;
    logic valid;
    logic ready;
    t_deb data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kpd_encoder.sv =====
`default_nettype none
module kpd_encoder
    import kpd_pkg::*;
(
    input  wire t_lines i_lines,
    output t_key        o_key
);

    // lowest set bit wins
    always_comb begin
        o_key = NO_KEY;
        for (int b = KEY_COUNT - 1; b >= 0; b--) begin
            if (i_lines[b]) begin
                o_key = KEY_W'(b + 1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/kpd_fsm.sv =====
`default_nettype none
module kpd_fsm
    import kpd_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_step  i_step,
    input  wire t_deb   i_debounce,
    output t_result     o_result
);

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_PRESSED   = 2'd1,
        ST_CONFIRMED = 2'd2,
        ST_RELEASED  = 2'd3
    } t_phase;

    t_phase r_phase, n_phase;
    t_key   r_cand, n_cand;
    t_tick  r_start, n_start;
    logic   r_held, n_held;
    t_key   r_out_key, n_out_key;
    logic   r_out_held;

    t_tick  elapsed;
    logic   expired;
    logic   adv;
    t_tick  now;
    t_key   raw;

    assign adv     = i_step.adv;
    assign now     = i_step.now_tick;
    assign raw     = i_step.raw_key;
    assign elapsed = now - r_start;
    assign expired = elapsed >= {{(TICK_W-DEB_W){1'b0}}, i_debounce};

    always_comb begin
        n_phase   = r_phase;
        n_cand    = r_cand;
        n_start   = r_start;
        n_held    = r_held;
        n_out_key = NO_KEY;
        unique case (r_phase)
            ST_IDLE: begin
                if (raw != NO_KEY) begin
                    n_cand  = raw;
                    n_start = now;
                    n_phase = ST_PRESSED;
                end
            end
            ST_PRESSED: begin
                if (raw == r_cand) begin
                    if (expired) begin
                        n_held    = 1'b1;
                        n_phase   = ST_CONFIRMED;
                        n_out_key = r_cand;
                    end
                end else if (raw == NO_KEY) begin
                    n_phase = ST_IDLE;
                end else begin
                    n_cand  = raw;
                    n_start = now;
                end
            end
            ST_CONFIRMED: begin
                if (raw == NO_KEY) begin
                    n_start = now;
                    n_phase = ST_RELEASED;
                end
            end
            ST_RELEASED: begin
                if (raw == NO_KEY) begin
                    if (expired) begin
                        n_held  = 1'b0;
                        n_phase = ST_IDLE;
                    end
                end else begin
                    n_cand  = raw;
                    n_start = now;
                    n_phase = ST_PRESSED;
                end
            end
            default: begin
                n_phase = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ST_IDLE;
            r_cand     <= NO_KEY;
            r_start    <= '0;
            r_held     <= 1'b0;
            r_out_key  <= NO_KEY;
            r_out_held <= 1'b0;
        end else if (adv) begin
            r_phase    <= n_phase;
            r_cand     <= n_cand;
            r_start    <= n_start;
            r_held     <= n_held;
            r_out_key  <= n_out_key;
            r_out_held <= n_held;
        end
    end

    assign o_result.confirmed_key = r_out_key;
    assign o_result.held_flag     = r_out_held;

    a_key_implies_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_key != NO_KEY) |-> r_out_held)
        else $error("confirmed key without held flag");

    a_no_repeat_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_phase == ST_CONFIRMED) |=> (r_out_key == NO_KEY))
        else $error("key confirmed twice");

    a_pressed_has_cand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ST_PRESSED) |-> (r_cand != NO_KEY))
        else $error("pressed phase with empty candidate");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> ($stable(r_phase) && $stable(r_start) && $stable(r_out_key)))
        else $error("state moved without an item");

endmodule
`default_nettype wire

// ===== rtl/core/keypad_scan_debouncer_top.sv =====
// Channel | Dir | Payload                          | Handshake
// i_in    | in  | now_tick[31:0], key_lines[15:0]  | valid/ready
// o_out   | out | confirmed_key[4:0], held_flag    | valid/ready
// i_cfg   | in  | data[15:0] -> debounce_ticks     | valid/ready, ready always high
//
// One word per cycle sustained while the result is not stalled; a word passes
// the input register, then the debounce step into the result register.
// Reset (synchronous, i_rst_n low) sets phase idle, held clear, debounce 20.
// A stalled result holds the step stage; the input register still takes a
// word while it is empty, so ready falls only when both stages are full.
`default_nettype none
module keypad_scan_debouncer_top
    import kpd_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    kpd_in_if.sink    i_in,
    kpd_out_if.source o_out,
    kpd_cfg_if.sink   i_cfg
);

    logic    r_in_valid;
    t_tick   r_now;
    t_lines  r_lines;
    logic    r_out_valid;
    t_deb    r_debounce;
    logic    adv;
    t_key    raw_key;
    t_step   step;
    t_result result;

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_debounce  <= DEBOUNCE_RESET;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                r_debounce <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_now   <= i_in.now_tick;
            r_lines <= i_in.key_lines;
        end
    end

    kpd_encoder u_encoder (
        .i_lines (r_lines),
        .o_key   (raw_key)
    );

    assign step.adv      = adv;
    assign step.now_tick = r_now;
    assign step.raw_key  = raw_key;

    kpd_fsm u_fsm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_debounce (r_debounce),
        .o_result   (result)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.confirmed_key = result.confirmed_key;
    assign o_out.held_flag     = result.held_flag;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import kpd_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {
        KP_IDLE,
        KP_PRESSED,
        KP_CONFIRMED,
        KP_RELEASED
    } t_kp_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    kpd_in_if  in_if ();
    kpd_out_if out_if ();
    kpd_cfg_if cfg_if ();

    keypad_scan_debouncer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // debouncer prediction state
    t_kp_phase kp_phase;
    t_key      kp_cand;
    t_key      kp_stable;
    t_tick     kp_start;
    logic      kp_held;
    t_deb      kp_deb;

    t_result expected_q[$];

    int in_idle_pct;
    int out_stall_pct;
    int mismatches;
    int words_sent;
    int results_checked;
    int confirms_expected;
    int cfg_writes;
    int idle_cycles;

    function automatic t_key lowest_key(t_lines lines);
        for (int b = 0; b < KEY_COUNT; b++) begin
            if (lines[b]) begin
                return t_key'(b + 1);
            end
        end
        return NO_KEY;
    endfunction

    function automatic t_result debounce_step(t_tick now, t_lines lines);
        t_key    raw;
        t_result res;
        logic    expired;
        raw = lowest_key(lines);
        expired = (now - kp_start) >= kp_deb;
        res.confirmed_key = NO_KEY;
        case (kp_phase)
            KP_IDLE: begin
                if (raw != NO_KEY) begin
                    kp_cand  = raw;
                    kp_start = now;
                    kp_phase = KP_PRESSED;
                end
            end
            KP_PRESSED: begin
                if (raw == kp_cand) begin
                    if (expired) begin
                        kp_stable         = kp_cand;
                        kp_held           = 1'b1;
                        kp_phase          = KP_CONFIRMED;
                        res.confirmed_key = kp_cand;
                    end
                end else if (raw == NO_KEY) begin
                    kp_phase = KP_IDLE;
                end else begin
                    kp_cand  = raw;
                    kp_start = now;
                end
            end
            KP_CONFIRMED: begin
                if (raw == NO_KEY) begin
                    kp_start = now;
                    kp_phase = KP_RELEASED;
                end
            end
            default: begin
                if (raw == NO_KEY) begin
                    if (expired) begin
                        kp_held   = 1'b0;
                        kp_stable = NO_KEY;
                        kp_phase  = KP_IDLE;
                    end
                end else begin
                    kp_cand  = raw;
                    kp_start = now;
                    kp_phase = KP_PRESSED;
                end
            end
        endcase
        res.held_flag = kp_held;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    task automatic send_scan(input t_tick now, input t_lines lines);
        t_result res;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.now_tick  <= now;
        in_if.key_lines <= lines;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        res = debounce_step(now, lines);
        expected_q.push_back(res);
        words_sent++;
        if (res.confirmed_key != NO_KEY) confirms_expected++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_debounce(input t_deb value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        kp_deb = value;
        cfg_writes++;
    endtask

    // default debounce of 20 ticks: press, confirm on the boundary, release
    task automatic test_press_and_release();
        send_scan(32'd0,   16'h0000);
        send_scan(32'd100, 16'h0001);
        send_scan(32'd119, 16'h0001);
        send_scan(32'd120, 16'h0001);
        send_scan(32'd125, 16'h0000);
        send_scan(32'd130, 16'h0000);
        send_scan(32'd145, 16'h0000);
    endtask

    task automatic test_candidate_switch();
        send_scan(32'd200, 16'h8000);
        send_scan(32'd210, 16'h0100);
        send_scan(32'd225, 16'h0100);
        send_scan(32'd230, 16'h0100);
        send_scan(32'd240, 16'h0000);
        send_scan(32'd260, 16'h0000);
    endtask

    // another key appears during release, vanishes, then a new key confirms
    task automatic test_release_bounce();
        send_scan(32'd300, 16'hFFFF);
        send_scan(32'd320, 16'hFFFF);
        send_scan(32'd330, 16'h0000);
        send_scan(32'd335, 16'h0004);
        send_scan(32'd340, 16'h0000);
        send_scan(32'd360, 16'h0010);
        send_scan(32'd380, 16'h0010);
        send_scan(32'd390, 16'h0000);
        send_scan(32'd410, 16'h0000);
    endtask

    task automatic test_zero_debounce();
        write_debounce(16'd0);
        send_scan(32'd500, 16'h8000);
        send_scan(32'd500, 16'h8000);
        send_scan(32'd500, 16'h0000);
        send_scan(32'd500, 16'h0000);
    endtask

    task automatic test_tick_wrap();
        write_debounce(16'hFFFF);
        send_scan(32'hFFFF_FFF0, 16'h0800);
        send_scan(32'h0000_FFEE, 16'h0800);
        send_scan(32'h0000_FFEF, 16'h0800);
        send_scan(32'h0001_0000, 16'h0000);
        send_scan(32'hFFFF_FFFF, 16'h0000);
    endtask

    // mostly steady keys and releases with bounce noise on top
    task automatic test_random_scans(input int count, input int in_pct, input int out_pct,
                                     input t_deb deb);
        t_lines target;
        t_lines lines;
        t_tick  tick;
        int     hold_left;
        int     bit_pos;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        write_debounce(deb);
        tick      = $urandom;
        target    = '0;
        hold_left = 0;
        for (int n = 0; n < count; n++) begin
            if (hold_left == 0) begin
                hold_left = $urandom_range(1, 8);
                if (target != '0) begin
                    target = '0;
                end else begin
                    bit_pos = $urandom_range(0, 15);
                    target  = t_lines'(1) << bit_pos;
                    if ($urandom_range(0, 1) == 1) target |= t_lines'($urandom) << bit_pos;
                end
            end
            hold_left--;
            case ($urandom_range(0, 19))
                0:       lines = t_lines'($urandom);
                1:       lines = '0;
                2:       lines = target ^ (t_lines'(1) << $urandom_range(0, 15));
                default: lines = target;
            endcase
            if ($urandom_range(0, 99) == 0) tick += $urandom;
            else tick += $urandom_range(0, deb / 2 + 1);
            send_scan(tick, lines);
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected word", 0, 32'(out_if.confirmed_key));
            end else begin
                want = expected_q.pop_front();
                if (out_if.confirmed_key !== want.confirmed_key)
                    report_mismatch("confirmed_key", 32'(want.confirmed_key),
                                    32'(out_if.confirmed_key));
                if (out_if.held_flag !== want.held_flag)
                    report_mismatch("held_flag", 32'(want.held_flag), 32'(out_if.held_flag));
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("** keypad_scan_debouncer_top: FAILED **");
            $finish;
        end
    end

    initial begin
        in_if.valid     <= 1'b0;
        in_if.now_tick  <= '0;
        in_if.key_lines <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.data     <= '0;
        i_rst_n         <= 1'b0;
        kp_phase          = KP_IDLE;
        kp_cand           = NO_KEY;
        kp_stable         = NO_KEY;
        kp_start          = '0;
        kp_held           = 1'b0;
        kp_deb            = DEBOUNCE_RESET;
        in_idle_pct       = 20;
        out_stall_pct     = 72;
        mismatches        = 0;
        words_sent        = 0;
        results_checked   = 0;
        confirms_expected = 0;
        cfg_writes        = 0;
        idle_cycles       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_press_and_release();
        test_candidate_switch();
        test_release_bounce();
        test_zero_debounce();
        test_tick_wrap();
        test_random_scans(150, 20, 72, t_deb'($urandom_range(1, 12)));
        test_random_scans(150, 72, 20, t_deb'($urandom_range(0, 2)));
        test_random_scans(150, 0, 0, t_deb'($urandom_range(20, 60)));
        wait_drained();

        $display("run covered %0d scan words, %0d results checked, %0d key confirmations",
                 words_sent, results_checked, confirms_expected);
        $display("%0d debounce settings incl. 0 and 65535, tick wrap, bouncing keys",
                 cfg_writes);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("** keypad_scan_debouncer_top: PASSED **");
        end else begin
            $display("** keypad_scan_debouncer_top: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
